// ===== hw/rtl/frustum_sphere_culling_assert.svh =====
// assertion macros for the frustum sphere culling block
// expects clk and rst_n in the scope of the module that uses them
`ifndef FRUSTUM_SPHERE_CULLING_ASSERT_SVH
`define FRUSTUM_SPHERE_CULLING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FSC_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("frustum sphere culling check failed");
`define FSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum sphere culling check failed");
`else
`define FSC_ASSERT_ALWAYS(name, expr)
`define FSC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hw/rtl/fsc_pkg.sv =====
// shared types and codes of the frustum sphere culling block
// no dependencies
package fsc_pkg;

  localparam logic [1:0] MODE_LOAD      = 2'd0;
  localparam logic [1:0] MODE_TEST      = 2'd1;
  localparam logic [1:0] MODE_TEST_FAR  = 2'd2;

  localparam logic [2:0] PLANE_NEAR = 3'd4;
  localparam logic [2:0] PLANE_LAST = 3'd5;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_ROW,
    DP_CAPTURE,
    DP_PLANE_VEC,
    DP_SQ,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WRITE,
    DP_TEST,
    DP_CHECK
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] plane;
    logic [1:0] comp;
  } fsc_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic visible;
  } fsc_status_t;

endpackage

// ===== hw/rtl/fsc_datapath.sv =====
// datapath: matrix rows, plane table, shared multiplier, root and divide units
// depends on fsc_pkg
module fsc_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_row_index,
  input  logic signed [31:0]  in_first_value,
  input  logic signed [31:0]  in_second_value,
  input  logic signed [31:0]  in_third_value,
  input  logic signed [31:0]  in_fourth_value,
  input  fsc_pkg::fsc_cmd_t   cmd,
  output fsc_pkg::fsc_status_t status
);
  import fsc_pkg::*;

  localparam int NumW = 32 + FRAC_BITS;
  localparam logic [NumW-1:0] QMaxPos = NumW'(64'h7FFF_FFFF);
  localparam logic [NumW-1:0] QMaxNeg = NumW'(64'h8000_0000);

  logic signed [31:0] row_r   [4][4];
  logic signed [31:0] plane_r [6][4];
  logic signed [31:0] vec_r   [4];
  logic signed [31:0] cen_r   [4];   // x, y, z, radius
  logic signed [65:0] prod_r, acc_r;
  logic [63:0]        sq_x_r, sq_root_r, sq_bit_r;
  logic [NumW-1:0]    num_r;
  logic [31:0]        rem_r;
  logic               neg_r, fail_r;

  logic signed [31:0] vec_nxt [4];
  logic [31:0]        vec_mag [4];
  logic signed [32:0] mul_a, mul_b;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [32:0]        rem2;
  logic               div_ge;
  logic [31:0]        div_res;
  logic signed [31:0] pl_sel [4];

  // plane vector from row 3 and the source row, saturated
  always_comb begin
    logic signed [32:0] s;
    for (int c = 0; c < 4; c++) begin
      if (cmd.plane[0])
        s = 33'(row_r[3][c]) - 33'(row_r[cmd.plane[2:1]][c]);
      else
        s = 33'(row_r[3][c]) + 33'(row_r[cmd.plane[2:1]][c]);
      if (s > 33'sh0_7FFF_FFFF)       vec_nxt[c] = 32'sh7FFF_FFFF;
      else if (s < -33'sh0_8000_0000) vec_nxt[c] = 32'sh8000_0000;
      else                            vec_nxt[c] = s[31:0];
      vec_mag[c] = vec_r[c][31] ? 32'd0 - vec_r[c] : vec_r[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) pl_sel[c] = plane_r[cmd.plane][c];
    if (cmd.op == DP_SQ) begin
      mul_a = {1'b0, vec_mag[cmd.comp]};
      mul_b = {1'b0, vec_mag[cmd.comp]};
    end else begin
      mul_a = 33'(pl_sel[cmd.comp]);
      mul_b = 33'(cen_r[cmd.comp]);
    end
  end

  assign trial  = sq_root_r + sq_bit_r;
  assign sq_ge  = sq_x_r >= trial;
  assign rem2   = {rem_r, num_r[NumW-1]};
  assign div_ge = rem2 >= {1'b0, sq_root_r[31:0]};

  // signed saturation of the quotient
  always_comb begin
    if (neg_r) begin
      if (num_r > QMaxNeg) div_res = 32'h8000_0000;
      else                 div_res = 32'd0 - num_r[31:0];
    end else begin
      if (num_r > QMaxPos) div_res = 32'h7FFF_FFFF;
      else                 div_res = num_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) row_r[r][c] <= '0;
      for (int p = 0; p < 6; p++)
        for (int c = 0; c < 4; c++) plane_r[p][c] <= '0;
      fail_r <= 1'b0;
    end else begin
      case (cmd.op)
        DP_LOAD_ROW: begin
          row_r[in_row_index][0] <= in_first_value;
          row_r[in_row_index][1] <= in_second_value;
          row_r[in_row_index][2] <= in_third_value;
          row_r[in_row_index][3] <= in_fourth_value;
        end
        DP_CAPTURE: fail_r <= 1'b0;
        DP_DIV_WRITE: plane_r[cmd.plane][cmd.comp] <=
          (sq_root_r == 64'd0) ? vec_r[cmd.comp] : div_res;
        DP_CHECK: fail_r <= fail_r | acc_r[65];
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        cen_r[0] <= in_first_value;
        cen_r[1] <= in_second_value;
        cen_r[2] <= in_third_value;
        cen_r[3] <= in_fourth_value;
      end
      DP_PLANE_VEC: for (int c = 0; c < 4; c++) vec_r[c] <= vec_nxt[c];
      DP_SQ: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= (cmd.comp == 2'd0) ? 66'sd0 : acc_r + prod_r;
      end
      DP_TEST: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= (cmd.comp == 2'd0) ? 66'(pl_sel[3]) + 66'(cen_r[3])
                                     : acc_r + (prod_r >>> FRAC_BITS);
      end
      DP_SQRT_INIT: begin
        sq_x_r    <= acc_r[63:0];
        sq_root_r <= 64'd0;
        sq_bit_r  <= 64'h4000_0000_0000_0000;
      end
      DP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_x_r    <= sq_x_r - trial;
          sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      DP_DIV_INIT: begin
        neg_r <= vec_r[cmd.comp][31];
        num_r <= {vec_mag[cmd.comp], FRAC_BITS'(0)};
        rem_r <= 32'd0;
      end
      DP_DIV_STEP: begin
        rem_r <= div_ge ? 32'(rem2 - {1'b0, sq_root_r[31:0]}) : rem2[31:0];
        num_r <= {num_r[NumW-2:0], div_ge};
      end
      default: ;
    endcase
  end

  assign status.len_zero = (sq_root_r == 64'd0);
  assign status.visible  = !fail_r;

endmodule

// ===== hw/rtl/fsc_ctrl.sv =====
// controller: sequences plane rebuilds and sphere tests, owns the handshakes
// depends on fsc_pkg
module fsc_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fsc_pkg::fsc_status_t status,
  output fsc_pkg::fsc_cmd_t    cmd
);
  import fsc_pkg::*;

  localparam int NumW = 32 + FRAC_BITS;
  localparam int CntW = $clog2(NumW);

  typedef enum logic [3:0] {
    S_IDLE, S_PV, S_SQ, S_SQRT_INIT, S_SQRT, S_DINIT, S_DIV, S_WR, S_TST, S_CHK, S_OUT
  } state_t;

  state_t          state_r;
  logic [2:0]      plane_r;
  logic [1:0]      comp_r;
  logic [CntW-1:0] cnt_r;
  logic            skip_near_r;
  logic            out_valid_r;
  logic            accept;
  logic [2:0]      next_plane;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    next_plane = plane_r + 3'd1;
    if (skip_near_r && next_plane == PLANE_NEAR) next_plane = PLANE_LAST;
  end

  always_comb begin
    cmd.op    = DP_NOP;
    cmd.plane = plane_r;
    cmd.comp  = comp_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        if (in_mode == MODE_LOAD) cmd.op = DP_LOAD_ROW;
        else if (in_mode == MODE_TEST || in_mode == MODE_TEST_FAR) cmd.op = DP_CAPTURE;
      end
      S_PV:        cmd.op = DP_PLANE_VEC;
      S_SQ:        cmd.op = DP_SQ;
      S_SQRT_INIT: cmd.op = DP_SQRT_INIT;
      S_SQRT:      cmd.op = DP_SQRT_STEP;
      S_DINIT:     cmd.op = DP_DIV_INIT;
      S_DIV:       cmd.op = DP_DIV_STEP;
      S_WR:        cmd.op = DP_DIV_WRITE;
      S_TST:       cmd.op = DP_TEST;
      S_CHK:       cmd.op = DP_CHECK;
      S_OUT:       cmd.op = DP_NOP;
      default:     cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plane_r     <= 3'd0;
      comp_r      <= 2'd0;
      cnt_r       <= '0;
      skip_near_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (accept) begin
          plane_r <= 3'd0;
          comp_r  <= 2'd0;
          if (in_mode == MODE_LOAD) begin
            state_r <= S_PV;
          end else if (in_mode == MODE_TEST || in_mode == MODE_TEST_FAR) begin
            skip_near_r <= (in_mode == MODE_TEST_FAR);
            state_r     <= S_TST;
          end
        end
        S_PV: begin
          comp_r  <= 2'd0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd3) state_r <= S_SQRT_INIT;
        end
        S_SQRT_INIT: begin
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(31)) begin
            comp_r  <= 2'd0;
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          cnt_r   <= '0;
          state_r <= status.len_zero ? S_WR : S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(NumW - 1)) state_r <= S_WR;
        end
        S_WR: begin
          comp_r <= comp_r + 2'd1;
          if (comp_r != 2'd3) begin
            state_r <= S_DINIT;
          end else if (plane_r == PLANE_LAST) begin
            state_r <= S_IDLE;
          end else begin
            plane_r <= plane_r + 3'd1;
            state_r <= S_PV;
          end
        end
        S_TST: begin
          comp_r <= comp_r + 2'd1;
          if (comp_r == 2'd3) state_r <= S_CHK;
        end
        S_CHK: begin
          comp_r <= 2'd0;
          if (plane_r == PLANE_LAST) begin
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            plane_r <= next_plane;
            state_r <= S_TST;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/frustum_sphere_culling.sv =====
// a sphere test walks the tested planes in turn, skipping near for MODE_TEST_FAR, and then
//   raises out_valid; one item is in flight at a time
// a new test is taken only after the previous result has been taken and the block is idle
// a row load rebuilds all six planes: per plane the sums, squares and the 32-step root,
//   then a bit-serial divide for each of the four components
// synchronous active-low reset clears matrix rows and planes to zero
`include "frustum_sphere_culling_assert.svh"
// top level: controller plus datapath, depends on fsc_pkg, fsc_ctrl, fsc_datapath
module frustum_sphere_culling #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_first_value,
  input  logic signed [31:0] in_second_value,
  input  logic signed [31:0] in_third_value,
  input  logic signed [31:0] in_fourth_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_visible
);
  import fsc_pkg::*;

  fsc_cmd_t    cmd;
  fsc_status_t status;

  // controller: accepts one transfer, walks planes, holds the result until taken
  fsc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: one shared multiplier, iterative root and restoring divider
  fsc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_row_index    (in_row_index),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .in_third_value  (in_third_value),
    .in_fourth_value (in_fourth_value),
    .cmd             (cmd),
    .status          (status)
  );

  // visible comes straight from the sticky fail flag, stable while out_valid waits
  assign out_visible = status.visible;

  // never ready for input while a result is pending
  `FSC_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid))
  // a test transfer always blocks the input side next cycle
  `FSC_ASSERT_NEXT(a_test_busy, in_valid && in_ready && in_mode == MODE_TEST, !in_ready)
  // after the result transfer the block is free again
  `FSC_ASSERT_NEXT(a_out_free, out_valid && out_ready, in_ready && !out_valid)

endmodule

// ===== test/fsc_checker.sv =====
// checker for frustum_sphere_culling: tracks matrix loads, rebuilds the planes
// and predicts the visibility result of every sphere test; depends on fsc_pkg
module fsc_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_first_value,
  input  logic signed [31:0] in_second_value,
  input  logic signed [31:0] in_third_value,
  input  logic signed [31:0] in_fourth_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_visible,
  output int                 fail_count,
  output int                 pending_results
);
  import fsc_pkg::*;

  logic signed [31:0] mat_elem [16];
  logic signed [31:0] plane_coef [24];
  bit visible_expected [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint norm_divide(longint num, longint unsigned len);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag << FRAC_BITS) / len;
    if (num < 0) return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
  endfunction

  task automatic rebuild_planes();
    longint v [4];
    longint unsigned sq, len, m;
    longint a, b;
    for (int p = 0; p < 6; p++) begin
      sq = 0;
      for (int c = 0; c < 4; c++) begin
        a = mat_elem[12 + c];
        b = mat_elem[4 * (p >> 1) + c];
        v[c] = clamp32(p[0] ? a - b : a + b);
      end
      for (int c = 0; c < 3; c++) begin
        m = (v[c] < 0) ? longint'(-v[c]) : longint'(v[c]);
        sq += m * m;
      end
      len = sqrt_floor(sq);
      // zero length normal: plane kept undivided
      for (int c = 0; c < 4; c++)
        plane_coef[4 * p + c] = (len > 0) ? 32'(norm_divide(v[c], len)) : 32'(v[c]);
    end
  endtask

  function automatic bit sphere_visible(logic [1:0] mode, longint cx, longint cy,
                                        longint cz, longint rad);
    longint d;
    for (int p = 0; p < 6; p++) begin
      if (mode == MODE_TEST_FAR && p == int'(PLANE_NEAR)) continue;
      // arithmetic shift floors each product
      d = ((longint'(plane_coef[4 * p]) * cx) >>> FRAC_BITS)
        + ((longint'(plane_coef[4 * p + 1]) * cy) >>> FRAC_BITS)
        + ((longint'(plane_coef[4 * p + 2]) * cz) >>> FRAC_BITS)
        + longint'(plane_coef[4 * p + 3]);
      if (d < -rad) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    pending_results = 0;
    foreach (mat_elem[i]) mat_elem[i] = '0;
    foreach (plane_coef[i]) plane_coef[i] = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_mode == MODE_LOAD) begin
          mat_elem[4 * in_row_index]     = in_first_value;
          mat_elem[4 * in_row_index + 1] = in_second_value;
          mat_elem[4 * in_row_index + 2] = in_third_value;
          mat_elem[4 * in_row_index + 3] = in_fourth_value;
          rebuild_planes();
        end else if (in_mode == MODE_TEST || in_mode == MODE_TEST_FAR) begin
          visible_expected.push_back(sphere_visible(in_mode, in_first_value,
            in_second_value, in_third_value, in_fourth_value));
        end
      end
      if (out_valid && out_ready) begin
        if (visible_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0b", $time,
                   out_visible);
          fail_count++;
        end else if (visible_expected[0] !== out_visible) begin
          $display("%0t: visible mismatch, expected %0b actual %0b", $time,
                   visible_expected[0], out_visible);
          fail_count++;
          void'(visible_expected.pop_front());
        end else begin
          void'(visible_expected.pop_front());
        end
      end
      pending_results = visible_expected.size();
    end
  end
endmodule

// ===== test/tb_frustum_sphere_culling.sv =====
// testbench top for frustum_sphere_culling: drives loads and sphere tests under
// varying idle and stall patterns; depends on fsc_pkg, fsc_checker and the block
module tb_frustum_sphere_culling;
  import fsc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ONE = 65536;
  // phases of the run
  localparam int PH_FREE   = 0;
  localparam int PH_SEND   = 1;
  localparam int PH_RECV   = 2;
  localparam int PH_BOTH   = 3;
  localparam int PH_HOLD   = 4;
  localparam int HOLD_CYCLES = 300;
  // longest correct silence is a plane rebuild
  localparam int SILENCE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1400;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_visible;
  logic [1:0] in_mode, in_row_index;
  logic signed [31:0] in_first_value, in_second_value, in_third_value, in_fourth_value;
  int fail_count, pending_results;
  int phase;
  bit hold_done;
  int quiet_cycles;

  frustum_sphere_culling uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_row_index,
    .in_first_value, .in_second_value, .in_third_value, .in_fourth_value,
    .out_valid, .out_ready, .out_visible
  );

  fsc_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_row_index,
    .in_first_value, .in_second_value, .in_third_value, .in_fourth_value,
    .out_valid, .out_ready, .out_visible, .fail_count, .pending_results
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // random Q16.16 value: mostly a few units, sometimes wide or extreme
  function automatic logic [31:0] rand_fixed();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom_range(0, 8 * ONE) - 4 * ONE;
    if (sel < 75) return $urandom_range(0, 2048 * ONE) - 1024 * ONE;
    if (sel < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // one transfer on the input channel; called at a falling edge
  task automatic send(logic [1:0] mode, logic [1:0] row, logic [31:0] a,
                      logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int idle_pct;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_row_index <= row;
    in_first_value <= a;
    in_second_value <= b;
    in_third_value <= c;
    in_fourth_value <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    idle_pct = (phase == PH_SEND) ? 57 : (phase == PH_BOTH) ? 15 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic send_random();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8)
      send(MODE_LOAD, 2'($urandom), rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
    else if (sel < 11)
      send(MODE_UNUSED, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    else
      send(sel[0] ? MODE_TEST : MODE_TEST_FAR, 2'($urandom), rand_fixed(),
           rand_fixed(), rand_fixed(), rand_fixed());
  endtask

  // result side: stalls by phase, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (phase == PH_HOLD && !hold_done) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_done = 1'b1;
      out_ready <= 1'b1;
    end else if (phase == PH_RECV) begin
      out_ready <= ($urandom_range(0, 99) >= 57);
    end else if (phase == PH_BOTH) begin
      out_ready <= ($urandom_range(0, 99) >= 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= SILENCE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    phase = PH_FREE;
    hold_done = 1'b0;
    quiet_cycles = 0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD;
    in_row_index = '0;
    in_first_value = '0;
    in_second_value = '0;
    in_third_value = '0;
    in_fourth_value = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all planes zero before any load: visible exactly when radius >= 0
    send(MODE_TEST, 2'd3, ONE, -ONE, 32'h7FFF_FFFF, 0);
    send(MODE_TEST, 2'd0, 0, 0, 0, -1);
    send(MODE_TEST_FAR, 2'd1, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
    send(MODE_TEST_FAR, 2'd2, 0, 0, 0, 32'h8000_0000);
    // unused mode gives no result
    send(MODE_UNUSED, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // identity rows: unit cube
    send(MODE_LOAD, 2'd0, ONE, 0, 0, 0);
    send(MODE_LOAD, 2'd1, 0, ONE, 0, 0);
    send(MODE_LOAD, 2'd2, 0, 0, ONE, 0);
    send(MODE_LOAD, 2'd3, 0, 0, 0, ONE);
    send(MODE_TEST, 2'd0, 0, 0, 0, 0);
    send(MODE_TEST, 2'd0, 3 * ONE, 0, 0, ONE);
    send(MODE_TEST, 2'd0, 3 * ONE, 0, 0, 2 * ONE);
    // point behind near plane, seen only when near is skipped
    send(MODE_TEST, 2'd0, 0, 0, -2 * ONE, ONE / 2);
    send(MODE_TEST_FAR, 2'd0, 0, 0, -2 * ONE, ONE / 2);
    // negative radius used as given
    send(MODE_TEST, 2'd0, 0, 0, 0, -ONE / 2);
    send(MODE_TEST, 2'd0, 0, 0, 0, -2 * ONE);
    // row 0 equal to row 3: right plane has zero length and stays undivided
    send(MODE_LOAD, 2'd0, 0, 0, 0, ONE);
    send(MODE_TEST, 2'd1, ONE, ONE, 0, 0);
    // extreme rows saturate sums and divides
    send(MODE_LOAD, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(MODE_LOAD, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send(MODE_TEST, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(MODE_TEST_FAR, 2'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    // tiny normal with a large offset
    send(MODE_LOAD, 2'd3, 0, 0, 0, 32'h7FFF_FFFF);
    send(MODE_LOAD, 2'd2, 1, 0, 0, 0);
    send(MODE_TEST, 2'd0, ONE, ONE, ONE, 0);

    for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
      phase = ph;
      repeat (400) send_random();
    end

    // long receiver hold-off while items keep coming
    phase = PH_HOLD;
    repeat (12) send(MODE_TEST, 2'($urandom), rand_fixed(), rand_fixed(), rand_fixed(),
                     rand_fixed());
    wait (hold_done);
    // sender pause until every result is in
    in_valid <= 1'b0;
    phase = PH_FREE;
    while (pending_results != 0) @(negedge clk);
    repeat (80) send_random();
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
